[rtl/modular_exponentiation_macros.svh]
// Assertion macros shared by the RTL.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MEXP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/mexp_pkg.sv]
`timescale 1ns / 1ps
package mexp_pkg;
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RED_GO,
		ST_RED,
		ST_MUL
	} mexp_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mm_status_t;

	localparam int unsigned FIELD_WIDTH = 32;
endpackage

[rtl/mexp_in_if.sv]
`timescale 1ns / 1ps
interface mexp_in_if;
	import mexp_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [FIELD_WIDTH-1:0] base_value;
	logic [FIELD_WIDTH-1:0] exponent_value;
	logic [FIELD_WIDTH-1:0] modulus_value;

	modport source (output valid, base_value, exponent_value, modulus_value, input ready);
	modport sink   (input valid, base_value, exponent_value, modulus_value, output ready);
endinterface

[rtl/mexp_out_if.sv]
`timescale 1ns / 1ps
interface mexp_out_if;
	import mexp_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [FIELD_WIDTH-1:0] power_result;

	modport source (output valid, power_result, input ready);
	modport sink   (input valid, power_result, output ready);
endinterface

[rtl/modular_exponentiation.sv]
`timescale 1ns / 1ps
`include "modular_exponentiation_macros.svh"
// Channel   | Role | Payload
// ----------+------+------------------------------------------------
// operands  | sink | base_value, exponent_value, modulus_value (32b)
// result    | src  | power_result (32b)
//
// One transaction at a time. Zero exponent or zero modulus: result is
// registered in the accept cycle and offered the next cycle.
// Otherwise: base reduction, then W rounds with both modular multipliers
// each running its own double-and-add step, which sets the run time.
// arst_n clears control only; operands is held low-ready while busy or
// while a finished result still waits on result.ready.
module modular_exponentiation #(
	parameter int unsigned OPERAND_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	mexp_in_if.sink    operands,
	mexp_out_if.source result
);
	import mexp_pkg::*;

	localparam int unsigned W  = OPERAND_WIDTH;
	localparam int unsigned CW = $clog2(W);

	mexp_state_t   state_q, state_d;
	logic [W-1:0]  base_q, acc_q, mod_q;
	logic [CW-1:0] round_q;
	logic [FIELD_WIDTH-1:0] res_q;
	logic          res_valid_q;

	logic          accept, last_round;
	logic [W-1:0]  in_base, in_exp, in_mod;
	logic          start_a, start_b, ebit;
	logic [W-1:0]  x_a, prod_a, prod_b;
	mm_status_t    st_a, st_b;
	logic [W:0]    ebits;

	// A round is outstanding once started until its done pulse.
	logic started_q;
	function automatic logic last_pending();
		return started_q;
	endfunction

	assign in_base = W'(operands.base_value);
	assign in_exp  = W'(operands.exponent_value);
	assign in_mod  = W'(operands.modulus_value);

	assign operands.ready = (state_q == ST_IDLE) && (!res_valid_q || result.ready);
	assign accept         = operands.valid && operands.ready;
	assign last_round     = (round_q == CW'(W - 1));

	// Exponent held in a row of bit cells; cell 0 is the bit of this round.
	assign ebits[W] = 1'b0;
	for (genvar i = 0; i < W; i++) begin : g_ecell
		mexp_ecell u_ecell (
			.clk      (clk),
			.load     (accept),
			.shift    (state_q == ST_MUL && st_a.done),
			.load_bit (in_exp[i]),
			.next_bit (ebits[i+1]),
			.bit_q    (ebits[i])
		);
	end
	assign ebit = ebits[0];

	// Multiplier A: base reduction (1 * base), then acc * base.
	// Multiplier B: base squaring. Both start together each round.
	assign x_a = (state_q == ST_RED_GO) ? W'(1) : acc_q;

	mexp_mulmod #(.W(W)) u_mul_a (
		.clk (clk), .arst_n (arst_n), .start (start_a),
		.x (x_a), .y (base_q), .m (mod_q),
		.product (prod_a), .status (st_a)
	);

	mexp_mulmod #(.W(W)) u_mul_b (
		.clk (clk), .arst_n (arst_n), .start (start_b),
		.x (base_q), .y (base_q), .m (mod_q),
		.product (prod_b), .status (st_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		start_a = 1'b0;
		start_b = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_exp != '0 && in_mod != '0) begin
					state_d = ST_RED_GO;
				end
			end
			ST_RED_GO: begin
				start_a = 1'b1;
				state_d = ST_RED;
			end
			ST_RED: begin
				if (st_a.done) begin
					start_a = 1'b0;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				// a round starts on entry (round counter primed) or after a round
				if (st_a.done) begin
					state_d = last_round ? ST_IDLE : ST_MUL;
				end
				start_a = !st_a.busy && !st_a.done && !last_pending();
				start_b = start_a;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (start_b) begin
				started_q <= 1'b1;
			end else if (state_q == ST_MUL && st_a.done) begin
				started_q <= 1'b0;
			end
			if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (accept && (in_exp == '0 || in_mod == '0)) begin
				res_valid_q <= 1'b1;
			end
			if (state_q == ST_MUL && st_a.done && last_round) begin
				res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q  <= in_base;
			mod_q   <= in_mod;
			round_q <= '0;
			res_q   <= (in_exp == '0) ? FIELD_WIDTH'(1) : '0;
		end
		if (state_q == ST_RED && st_a.done) begin
			base_q <= prod_a;
			acc_q  <= (mod_q == W'(1)) ? '0 : W'(1);
		end
		if (state_q == ST_MUL && st_a.done) begin
			base_q  <= prod_b;
			round_q <= round_q + 1'b1;
			if (ebit) begin
				acc_q <= prod_a;
			end
			res_q <= FIELD_WIDTH'(ebit ? prod_a : acc_q);
		end
	end

	assign result.valid        = res_valid_q;
	assign result.power_result = res_q;

	`MEXP_ASSERT_NOW(a_accept_idle, accept, state_q == ST_IDLE, "accept outside idle")
	`MEXP_ASSERT_NOW(a_done_busy, st_a.done, state_q == ST_RED || state_q == ST_MUL, "stray done")
	`MEXP_ASSERT_NOW(a_mul_lockstep, state_q == ST_MUL, st_a.done == st_b.done, "multipliers apart")
	`MEXP_ASSERT_NEXT(a_last_result, state_q == ST_MUL && st_a.done && last_round, result.valid,
		"no result after last round")
endmodule

[rtl/mexp_ecell.sv]
`timescale 1ns / 1ps
// One exponent bit; shifts towards the low end of the row.
module mexp_ecell (
	input  logic clk,
	input  logic load,
	input  logic shift,
	input  logic load_bit,
	input  logic next_bit,
	output logic bit_q
);
	always_ff @(posedge clk) begin
		if (load) begin
			bit_q <= load_bit;
		end else if (shift) begin
			bit_q <= next_bit;
		end
	end
endmodule

[rtl/mexp_mulmod.sv]
`timescale 1ns / 1ps
// (x * y) mod m by double-and-add, one multiplier bit per cycle, MSB first.
module mexp_mulmod #(
	parameter int unsigned W = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [W-1:0]            x,
	input  logic [W-1:0]            y,
	input  logic [W-1:0]            m,
	output logic [W-1:0]            product,
	output mexp_pkg::mm_status_t    status
);
	import mexp_pkg::*;

	localparam int unsigned CW = $clog2(W);

	logic [W-1:0]  acc_q, x_q, y_q, m_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [W-1:0]  dbl, nxt;

	function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
		input logic [W-1:0] md);
		logic [W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, md}) begin
			s = s - {1'b0, md};
		end
		return s[W-1:0];
	endfunction

	always_comb begin
		dbl = add_mod(acc_q, acc_q, m_q);
		nxt = y_q[W-1] ? add_mod(dbl, x_q, m_q) : dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
			m_q   <= m;
		end else if (busy_q) begin
			acc_q <= nxt;
			y_q   <= {y_q[W-2:0], 1'b0};
		end
	end

	assign product     = acc_q;
	assign status.busy = busy_q;
	assign status.done = done_q;
endmodule
